[rtl/sdp_pkg.sv]
// Shared widths, constants and types of the stroke dab placer.
// Used by every module of the block; depends on nothing.
package sdp_pkg;

  localparam int COORD_W   = 32;  // coordinate, Q23.8
  localparam int PRES_W    = 12;  // pen pressure
  localparam int PEN_W     = 16;  // pen width, Q8.8
  localparam int LEN_W     = 48;  // running arc length
  localparam int SEGL_W    = 36;  // one segment length, ten times the largest distance
  localparam int FRAC_W    = 17;  // fraction along a segment, Q16 up to one
  localparam int QS_W      = 32;  // fraction increment per dab
  localparam int QACC_W    = 34;  // fraction accumulator with headroom
  localparam int DVD_W     = 52;  // divider dividend and quotient
  localparam int CNT_W     = 6;   // iteration counters
  localparam int MAX_DABS  = 64;
  localparam int EMIT_W    = $clog2(MAX_DABS + 1);
  localparam int SQ_W      = 2 * COORD_W + 1;  // dx^2 + dy^2
  localparam int RAD_W     = SQ_W + 7;         // times the length scale of 100
  localparam int ROOT_W    = RAD_W / 2;

  // Arc length unit is 1/2560 of a coordinate unit; with eight fraction bits
  // the squared scale 2560^2 / 2^16 is 100.
  localparam int LEN_SCALE = 100;

  localparam logic [PEN_W-1:0] PEN_RESET = 16'd256;

  // floor(v / 5) for v below 2^18
  localparam logic [15:0] DIV5_MUL   = 16'd52429;
  localparam int          DIV5_SHIFT = 18;

  typedef struct packed {
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] adx;
    logic               sx;
    logic [COORD_W-1:0] y0;
    logic [COORD_W-1:0] ady;
    logic               sy;
    logic [PRES_W-1:0]  p0;
    logic [PRES_W-1:0]  adp;
    logic               sp;
    logic [FRAC_W-1:0]  f0;
    logic [SEGL_W-1:0]  r0;
    logic [QS_W-1:0]    qs;
    logic [SEGL_W-1:0]  rs;
    logic [SEGL_W-1:0]  len;
    logic [EMIT_W-1:0]  emit;
    logic               trunc;
  } desc_t;

  typedef struct packed {
    logic               start;
    logic [DVD_W-1:0]   dividend;  // aligned to the top bit
    logic [SEGL_W-1:0]  divisor;
    logic [CNT_W-1:0]   nbits;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DVD_W-1:0]   quo;
    logic [SEGL_W-1:0]  rem;
  } div_rsp_t;

endpackage

[rtl/stroke_dab_placer_core.sv]
// Top level of the stroke dab placer: pen width register, stream packing,
// and the front end, divider, descriptor queue and dab generator below it.
//
// Channel   Dir  Accepted when              Contents
// s_axis    in   s_axis_tvalid & tready     one stroke point
// m_axis    out  m_axis_tvalid & tready     one dab
// cfg       in   cfg_we_i high              pen width, Q8.8
//
// A point that starts a stroke only sets up the arc state. Other points pass
// three multiply steps, a bit-serial square root and one update step, then one
// division on the divider when drawing begins and three when the segment is drawn.
// Dabs then leave one per cycle after four stages while m_axis is ready. Reset
// clears all arc state and sets the pen width to 256. A stall on m_axis holds
// the dab pipeline; the two-entry queue lets the front end go on.
module stroke_dab_placer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,  // point_x, point_y, point_pressure, zero pad
  input  logic [1:0]  s_axis_tuser,  // new_stroke, draw_enable
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,  // dab_x, dab_y, dab_radius, dab_alpha
  output logic        m_axis_tlast,  // last_dab
  output logic        m_axis_tuser,  // truncated
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);
  import sdp_pkg::*;

  logic [PEN_W-1:0]   pen_q;
  logic               push, full, pop, empty;
  desc_t              desc_w, desc_r;
  div_req_t           div_req;
  div_rsp_t           div_rsp;
  logic [COORD_W-1:0] dab_x, dab_y;
  logic [15:0]        dab_radius;
  logic [7:0]         dab_alpha;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_q <= PEN_RESET;
    end else if (cfg_we_i) begin
      pen_q <= cfg_wdata_i;
    end
  end

  sdp_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_o       (s_axis_tready),
    .point_x_i        (s_axis_tdata[31:0]),
    .point_y_i        (s_axis_tdata[63:32]),
    .point_pressure_i (s_axis_tdata[75:64]),
    .new_stroke_i     (s_axis_tuser[0]),
    .draw_enable_i    (s_axis_tuser[1]),
    .pen_width_i      (pen_q),
    .push_o           (push),
    .desc_o           (desc_w),
    .full_i           (full),
    .div_req_o        (div_req),
    .div_rsp_i        (div_rsp)
  );

  sdp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  sdp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .desc_i  (desc_w),
    .full_o  (full),
    .pop_i   (pop),
    .desc_o  (desc_r),
    .empty_o (empty)
  );

  sdp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_i       (desc_r),
    .empty_i      (empty),
    .pop_o        (pop),
    .pen_width_i  (pen_q),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .dab_x_o      (dab_x),
    .dab_y_o      (dab_y),
    .dab_radius_o (dab_radius),
    .dab_alpha_o  (dab_alpha),
    .last_dab_o   (m_axis_tlast),
    .truncated_o  (m_axis_tuser)
  );

  assign m_axis_tdata = {dab_alpha, dab_radius, dab_y, dab_x};

endmodule

[rtl/sdp_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on sdp_pkg.
module sdp_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sdp_pkg::div_req_t req_i,
  output sdp_pkg::div_rsp_t rsp_o
);
  import sdp_pkg::*;

  logic              busy_q, busy_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DVD_W-1:0]  dq_q, dq_d;
  logic [SEGL_W-1:0] rem_q, rem_d;
  logic [SEGL_W-1:0] dvs_q, dvs_d;
  logic [SEGL_W:0]   rem_sh;
  logic              ge;

  assign rem_sh = {rem_q, dq_q[DVD_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dq_d   = dq_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.nbits;
      dq_d   = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        cnt_d = cnt_q - 1'b1;
        dq_d  = {dq_q[DVD_W-2:0], ge};
        rem_d = ge ? SEGL_W'(rem_sh - {1'b0, dvs_q}) : SEGL_W'(rem_sh);
      end else begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done = busy_q && (cnt_q == '0);
  assign rsp_o.quo  = dq_q;
  assign rsp_o.rem  = rem_q;

endmodule

[rtl/sdp_front.sv]
// Point front end: segment length, arc bookkeeping and dab spacing set-up.
// Depends on sdp_pkg; drives the divider and pushes segment descriptors.
module sdp_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [sdp_pkg::COORD_W-1:0] point_x_i,
  input  logic [sdp_pkg::COORD_W-1:0] point_y_i,
  input  logic [sdp_pkg::PRES_W-1:0]  point_pressure_i,
  input  logic                        new_stroke_i,
  input  logic                        draw_enable_i,
  input  logic [sdp_pkg::PEN_W-1:0]   pen_width_i,
  output logic                        push_o,
  output sdp_pkg::desc_t              desc_o,
  input  logic                        full_i,
  output sdp_pkg::div_req_t           div_req_o,
  input  sdp_pkg::div_rsp_t           div_rsp_i
);
  import sdp_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MULX, ST_MULY, ST_SCALE, ST_SQRT, ST_CALC,
    ST_DIVN, ST_DIVF, ST_DIVS, ST_DIVR, ST_PUSH
  } state_e;

  state_e state_q;

  logic [COORD_W-1:0] cx_q, cy_q, prev_x_q, prev_y_q, ax_q, ay_q;
  logic [PRES_W-1:0]  cp_q, prev_p_q;
  logic               draw_q, sx_q, sy_q, have_prev_q, prev_draw_q;
  logic [LEN_W-1:0]   run_q, next_q, end_q;
  logic [SQ_W-1:0]    sq_q;
  logic [RAD_W-1:0]   rad_q;
  logic [ROOT_W:0]    srem_q;
  logic [ROOT_W-1:0]  root_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [SEGL_W-1:0]  off0_q, r0_q, rs_q;
  logic [FRAC_W-1:0]  f0_q;
  logic [QS_W-1:0]    qs_q;
  logic [EMIT_W-1:0]  emit_q;
  logic               trunc_q;

  logic [PEN_W-1:0]   step;
  logic [COORD_W:0]   dx_w, dy_w;
  logic [2*COORD_W-1:0] sqx_w, sqy_w;
  logic [ROOT_W+2:0]  sq_sh, sq_trial;
  logic [SEGL_W-1:0]  len;
  logic [LEN_W:0]     run_sum, adv_sum;
  logic [LEN_W-1:0]   end_w, pos_w, adv_w;
  logic               seg, begin_draw, start_pt;
  logic               quo_big;

  assign step       = (pen_width_i == '0) ? PEN_W'(1) : pen_width_i;
  assign in_ready_o = (state_q == ST_IDLE);
  assign start_pt   = new_stroke_i || !have_prev_q;

  assign dx_w = {point_x_i[COORD_W-1], point_x_i} - {prev_x_q[COORD_W-1], prev_x_q};
  assign dy_w = {point_y_i[COORD_W-1], point_y_i} - {prev_y_q[COORD_W-1], prev_y_q};

  // Full-width squares of the coordinate differences.
  assign sqx_w = {{COORD_W{1'b0}}, ax_q} * {{COORD_W{1'b0}}, ax_q};
  assign sqy_w = {{COORD_W{1'b0}}, ay_q} * {{COORD_W{1'b0}}, ay_q};

  // One result bit of the square root per cycle.
  assign sq_sh    = {srem_q[ROOT_W:0], rad_q[RAD_W-1 -: 2]};
  assign sq_trial = {1'b0, root_q, 2'b01};

  assign len        = root_q;
  assign run_sum    = {1'b0, run_q} + {{(LEN_W+1-SEGL_W){1'b0}}, len};
  assign end_w      = run_sum[LEN_W] ? '1 : run_sum[LEN_W-1:0];
  assign pos_w      = (next_q < run_q) ? run_q : next_q;
  assign seg        = prev_draw_q && (len != '0) && (pos_w <= end_w);
  assign begin_draw = draw_q && !prev_draw_q;

  // Rounds end_q down to a whole step and adds one step, saturating.
  assign adv_sum = {1'b0, end_q - LEN_W'(div_rsp_i.rem)} + {{(LEN_W+1-PEN_W){1'b0}}, step};
  assign adv_w   = adv_sum[LEN_W] ? '1 : adv_sum[LEN_W-1:0];
  assign quo_big = div_rsp_i.quo >= DVD_W'(MAX_DABS);

  always_comb begin
    div_req_o = '0;
    case (state_q)
      ST_CALC: begin
        div_req_o.start    = seg || begin_draw;
        div_req_o.dividend = seg ? {end_w - pos_w, 4'b0} : {end_w, 4'b0};
        div_req_o.divisor  = SEGL_W'(step);
        div_req_o.nbits    = CNT_W'(LEN_W);
      end
      ST_DIVN: begin
        div_req_o.start    = div_rsp_i.done;
        div_req_o.dividend = {off0_q, 16'b0};
        div_req_o.divisor  = len;
        div_req_o.nbits    = CNT_W'(DVD_W);
      end
      ST_DIVF: begin
        div_req_o.start    = div_rsp_i.done;
        div_req_o.dividend = {step, {(DVD_W-PEN_W){1'b0}}};
        div_req_o.divisor  = len;
        div_req_o.nbits    = CNT_W'(PEN_W + 16);
      end
      default: div_req_o = '0;
    endcase
  end

  always_comb begin
    desc_o.x0    = prev_x_q;
    desc_o.adx   = ax_q;
    desc_o.sx    = sx_q;
    desc_o.y0    = prev_y_q;
    desc_o.ady   = ay_q;
    desc_o.sy    = sy_q;
    desc_o.p0    = prev_p_q;
    desc_o.sp    = cp_q < prev_p_q;
    desc_o.adp   = (cp_q < prev_p_q) ? prev_p_q - cp_q : cp_q - prev_p_q;
    desc_o.f0    = f0_q;
    desc_o.r0    = r0_q;
    desc_o.qs    = qs_q;
    desc_o.rs    = rs_q;
    desc_o.len   = len;
    desc_o.emit  = emit_q;
    desc_o.trunc = trunc_q;
  end

  assign push_o = (state_q == ST_PUSH) && !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      prev_p_q    <= '0;
      run_q       <= '0;
      next_q      <= '0;
      have_prev_q <= 1'b0;
      prev_draw_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            if (start_pt) begin
              prev_x_q    <= point_x_i;
              prev_y_q    <= point_y_i;
              prev_p_q    <= point_pressure_i;
              run_q       <= '0;
              next_q      <= '0;
              have_prev_q <= 1'b1;
              prev_draw_q <= draw_enable_i;
            end else begin
              state_q <= ST_MULX;
            end
          end
        end
        ST_MULX:  state_q <= ST_MULY;
        ST_MULY:  state_q <= ST_SCALE;
        ST_SCALE: begin
          cnt_q   <= CNT_W'(ROOT_W);
          state_q <= ST_SQRT;
        end
        ST_SQRT: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == CNT_W'(1)) begin
            state_q <= ST_CALC;
          end
        end
        ST_CALC: begin
          run_q <= end_w;
          if (prev_draw_q && (len != '0)) begin
            next_q <= pos_w;
          end
          if (seg) begin
            state_q <= ST_DIVN;
          end else if (begin_draw) begin
            state_q <= ST_DIVR;
          end else begin
            prev_x_q    <= cx_q;
            prev_y_q    <= cy_q;
            prev_p_q    <= cp_q;
            prev_draw_q <= draw_q;
            state_q     <= ST_IDLE;
          end
        end
        ST_DIVN: begin
          if (div_rsp_i.done) begin
            next_q  <= adv_w;
            state_q <= ST_DIVF;
          end
        end
        ST_DIVF: begin
          if (div_rsp_i.done) begin
            state_q <= ST_DIVS;
          end
        end
        ST_DIVS: begin
          if (div_rsp_i.done) begin
            state_q <= ST_PUSH;
          end
        end
        ST_DIVR: begin
          if (div_rsp_i.done) begin
            next_q      <= adv_w;
            prev_x_q    <= cx_q;
            prev_y_q    <= cy_q;
            prev_p_q    <= cp_q;
            prev_draw_q <= draw_q;
            state_q     <= ST_IDLE;
          end
        end
        ST_PUSH: begin
          if (!full_i) begin
            prev_x_q    <= cx_q;
            prev_y_q    <= cy_q;
            prev_p_q    <= cp_q;
            prev_draw_q <= draw_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers, no reset needed.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        cx_q   <= point_x_i;
        cy_q   <= point_y_i;
        cp_q   <= point_pressure_i;
        draw_q <= draw_enable_i;
        sx_q   <= dx_w[COORD_W];
        sy_q   <= dy_w[COORD_W];
        ax_q   <= dx_w[COORD_W] ? COORD_W'(-dx_w) : dx_w[COORD_W-1:0];
        ay_q   <= dy_w[COORD_W] ? COORD_W'(-dy_w) : dy_w[COORD_W-1:0];
      end
      ST_MULX: sq_q <= {1'b0, sqx_w};
      ST_MULY: sq_q <= sq_q + {1'b0, sqy_w};
      ST_SCALE: begin
        // times 100 as 64 + 32 + 4
        rad_q  <= RAD_W'({sq_q, 6'b0}) + RAD_W'({sq_q, 5'b0}) + RAD_W'({sq_q, 2'b0});
        srem_q <= '0;
        root_q <= '0;
      end
      ST_SQRT: begin
        rad_q <= {rad_q[RAD_W-3:0], 2'b0};
        if (sq_sh >= sq_trial) begin
          srem_q <= (ROOT_W+1)'(sq_sh - sq_trial);
          root_q <= {root_q[ROOT_W-2:0], 1'b1};
        end else begin
          srem_q <= (ROOT_W+1)'(sq_sh);
          root_q <= {root_q[ROOT_W-2:0], 1'b0};
        end
      end
      ST_CALC: begin
        end_q  <= end_w;
        off0_q <= SEGL_W'(pos_w - run_q);
      end
      ST_DIVN: begin
        if (div_rsp_i.done) begin
          trunc_q <= quo_big;
          emit_q  <= quo_big ? EMIT_W'(MAX_DABS) : EMIT_W'(div_rsp_i.quo + 1'b1);
        end
      end
      ST_DIVF: begin
        if (div_rsp_i.done) begin
          f0_q <= div_rsp_i.quo[FRAC_W-1:0];
          r0_q <= div_rsp_i.rem;
        end
      end
      ST_DIVS: begin
        if (div_rsp_i.done) begin
          qs_q <= div_rsp_i.quo[QS_W-1:0];
          rs_q <= div_rsp_i.rem;
        end
      end
      default: ;
    endcase
  end

endmodule

[rtl/sdp_queue.sv]
// Two-entry descriptor queue between front end and dab generator.
// Depends on sdp_pkg.
module sdp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sdp_pkg::desc_t desc_i,
  output logic           full_o,
  input  logic           pop_i,
  output sdp_pkg::desc_t desc_o,
  output logic           empty_o
);
  import sdp_pkg::*;

  desc_t       mem_q [2];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign desc_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop_i) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= desc_i;
    end
  end

endmodule

[rtl/sdp_back.sv]
// Dab generator: steps the segment fraction and interpolates each dab.
// Depends on sdp_pkg; pops descriptors from sdp_queue.
module sdp_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  sdp_pkg::desc_t              desc_i,
  input  logic                        empty_i,
  output logic                        pop_o,
  input  logic [sdp_pkg::PEN_W-1:0]   pen_width_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [sdp_pkg::COORD_W-1:0] dab_x_o,
  output logic [sdp_pkg::COORD_W-1:0] dab_y_o,
  output logic [15:0]                 dab_radius_o,
  output logic [7:0]                  dab_alpha_o,
  output logic                        last_dab_o,
  output logic                        truncated_o
);
  import sdp_pkg::*;

  localparam int PXW = COORD_W + FRAC_W;
  localparam int PPW = PRES_W + FRAC_W;

  // generator
  desc_t              g_q;
  logic               g_act_q;
  logic [EMIT_W-1:0]  k_q;
  logic [QACC_W-1:0]  q_q;
  logic [SEGL_W-1:0]  r_q;
  logic [SEGL_W:0]    r_sum;
  logic               g_last;

  // stages
  logic               v1_q, v2_q, v3_q, vo_q;
  logic [PXW-1:0]     px1_q, py1_q;
  logic [PPW-1:0]     pp1_q;
  logic [COORD_W-1:0] x01_q, y01_q, x2_q, y2_q, x3_q, y3_q;
  logic [PRES_W-1:0]  p01_q, p2_q;
  logic               sx1_q, sy1_q, sp1_q;
  logic               l1_q, l2_q, l3_q, t1_q, t2_q, t3_q;
  logic [29:0]        radp3_q;
  logic [20:0]        alpp3_q;
  logic [PXW-16:0]    dlx, dly;
  logic [PPW-16:0]    dlp;
  logic [33:0]        rad_m;
  logic [27:0]        alp_m;
  logic [9:0]         alp_w;
  logic               en;

  assign en     = !vo_q || out_ready_i;
  assign pop_o  = !g_act_q && !empty_i;
  assign g_last = (k_q == g_q.emit - 1'b1);
  assign r_sum  = {1'b0, r_q} + {1'b0, g_q.rs};

  assign dlx = (PXW-15)'(({1'b0, px1_q} + (PXW+1)'(32768)) >> 16);
  assign dly = (PXW-15)'(({1'b0, py1_q} + (PXW+1)'(32768)) >> 16);
  assign dlp = (PPW-15)'(({1'b0, pp1_q} + (PPW+1)'(32768)) >> 16);

  assign rad_m = radp3_q[29:12] * DIV5_MUL;
  assign alp_m = alpp3_q[20:9] * DIV5_MUL;
  assign alp_w = alp_m[DIV5_SHIFT +: 10];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_act_q <= 1'b0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      vo_q    <= 1'b0;
    end else begin
      if (pop_o) begin
        g_act_q <= 1'b1;
      end else if (en && g_act_q && g_last) begin
        g_act_q <= 1'b0;
      end
      if (en) begin
        v1_q <= g_act_q;
        v2_q <= v1_q;
        v3_q <= v2_q;
        vo_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      g_q <= desc_i;
      k_q <= '0;
      q_q <= QACC_W'(desc_i.f0);
      r_q <= desc_i.r0;
    end else if (en && g_act_q) begin
      // Exact quotient tracking: adding one step adds qs, plus one when the
      // remainders carry past the segment length.
      k_q <= k_q + 1'b1;
      if (r_sum >= {1'b0, g_q.len}) begin
        r_q <= SEGL_W'(r_sum - {1'b0, g_q.len});
        q_q <= q_q + QACC_W'(g_q.qs) + QACC_W'(1);
      end else begin
        r_q <= SEGL_W'(r_sum);
        q_q <= q_q + QACC_W'(g_q.qs);
      end
    end
    if (en) begin
      px1_q <= g_q.adx * q_q[FRAC_W-1:0];
      py1_q <= g_q.ady * q_q[FRAC_W-1:0];
      pp1_q <= g_q.adp * q_q[FRAC_W-1:0];
      x01_q <= g_q.x0;
      y01_q <= g_q.y0;
      p01_q <= g_q.p0;
      sx1_q <= g_q.sx;
      sy1_q <= g_q.sy;
      sp1_q <= g_q.sp;
      l1_q  <= g_last;
      t1_q  <= g_q.trunc;

      x2_q <= sx1_q ? x01_q - COORD_W'(dlx) : x01_q + COORD_W'(dlx);
      y2_q <= sy1_q ? y01_q - COORD_W'(dly) : y01_q + COORD_W'(dly);
      p2_q <= sp1_q ? p01_q - PRES_W'(dlp) : p01_q + PRES_W'(dlp);
      l2_q <= l1_q;
      t2_q <= t1_q;

      x3_q    <= x2_q;
      y3_q    <= y2_q;
      radp3_q <= pen_width_i * (14'd8192 + 14'(p2_q));
      alpp3_q <= 21'd255 * (21'd512 + 21'(p2_q));
      l3_q    <= l2_q;
      t3_q    <= t2_q;

      dab_x_o      <= x3_q;
      dab_y_o      <= y3_q;
      dab_radius_o <= rad_m[DIV5_SHIFT +: 16];
      dab_alpha_o  <= (alp_w > 10'd255) ? 8'd255 : alp_w[7:0];
      last_dab_o   <= l3_q;
      truncated_o  <= t3_q;
    end
  end

  assign out_valid_o = vo_q;

endmodule
